@@ design/chi_pkg.sv @@
// ----------------------------------------------------------------------------
// chi_pkg
// shared types, codes and constants of the chunk coordinate hash index
// ----------------------------------------------------------------------------
package chi_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 2048;
  localparam int unsigned KEY_W             = 64;
  localparam int unsigned ID_W              = 10;
  localparam int unsigned LIVE_W            = 12;

  localparam logic [31:0] HASH_MUL_X = 32'h9E3779B1;
  localparam logic [31:0] HASH_MUL_Z = 32'h85EBCA77;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] MARK_EMPTY    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_TOMB     = 2'd2;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  value;
  } slot_t;

  typedef struct packed {
    logic       in_ready;
    logic       latch_req;
    logic       hash_x;
    logic       hash_z;
    logic       hash_mix;
    logic       mod_step;
    logic       probe_rd;
    logic       probe_adv;
    logic       wr_update;
    logic       wr_place;
    logic       wr_erase;
    logic       idx_clr;
    logic       idx_inc;
    logic       clear_wr;
    logic       copy_rd;
    logic       copy_wr;
    logic       scan_rd;
    logic       counts_clr;
    logic       work_from_req;
    logic       work_from_scr;
    logic       res_load;
    logic       res_hit;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] rd_mark;
    logic       key_eq;
    logic       n_last;
    logic       have_tomb;
    logic       tomb_ge_lim;
    logic       tomb_nz;
    logic       idx_last;
    logic       mod_last;
    logic       scan_occ;
    logic [1:0] req_op;
    logic       out_free;
  } sts_t;

endpackage

@@ design/chi_in_if.sv @@
// ----------------------------------------------------------------------------
// chi_in_if
// request channel: operation, chunk coordinate and mesh id
// ----------------------------------------------------------------------------
interface chi_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [31:0] key_x;
  logic signed [31:0] key_z;
  logic [9:0]        value_id;

  modport source (output valid, output op, output key_x, output key_z, output value_id,
                  input ready);
  modport sink (input valid, input op, input key_x, input key_z, input value_id,
                output ready);
endinterface

@@ design/chi_out_if.sv @@
// ----------------------------------------------------------------------------
// chi_out_if
// response channel: status, found mesh id and occupied entry count
// ----------------------------------------------------------------------------
interface chi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  found_id;
  logic [11:0] occ_count;

  modport source (output valid, output status, output found_id, output occ_count,
                  input ready);
  modport sink (input valid, input status, input found_id, input occ_count,
                output ready);
endinterface

@@ design/chi_datapath.sv @@
// ----------------------------------------------------------------------------
// chi_datapath
// slot and scratch memories, hash unit, probe pointer, counters, result register
// ----------------------------------------------------------------------------
module chi_datapath #(
  parameter int unsigned TABLE_ENTRIES = chi_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chi_pkg::cmd_t                cmd_i,
  output chi_pkg::sts_t                sts_o,
  input  logic [1:0]                   op_i,
  input  logic [31:0]                  key_x_i,
  input  logic [31:0]                  key_z_i,
  input  logic [chi_pkg::ID_W-1:0]     value_id_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   out_status_o,
  output logic [chi_pkg::ID_W-1:0]     out_found_id_o,
  output logic [chi_pkg::LIVE_W-1:0]   out_occ_count_o
);

  localparam int unsigned IW      = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW      = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LIMIT   = TABLE_ENTRIES / 4;
  localparam bit          IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [31:0]   N_W   = 32'(TABLE_ENTRIES);
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST  = IW'(TABLE_ENTRIES - 1);

  chi_pkg::slot_t slot_mem [TABLE_ENTRIES];
  chi_pkg::slot_t scr_mem  [TABLE_ENTRIES];
  chi_pkg::slot_t slot_rd_q, scr_rd_q;

  logic [1:0]                 req_op_q;
  logic [chi_pkg::KEY_W-1:0]  req_key_q, work_key_q;
  logic [chi_pkg::ID_W-1:0]   req_val_q, work_val_q;
  logic [31:0]                hx_q, hz_q, h_q, mix;
  logic [31:0]                quo_q, qn_q, diff;
  logic [63:0]                prod;
  logic [IW-1:0]              rem_d;
  logic [1:0]                 step_q;
  logic [IW-1:0]              p_q, n_q, tomb_p_q, idx_q, p_next;
  logic                       have_tomb_q;
  logic [CW-1:0]              occ_q, tcnt_q;
  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic [chi_pkg::ID_W-1:0]   out_found_q;
  logic [chi_pkg::LIVE_W-1:0] out_live_q;

  logic           wr_en, rd_en;
  logic [IW-1:0]  wr_addr, rd_addr;
  chi_pkg::slot_t wr_data;
  logic           mod_last;

  assign mix      = hx_q ^ hz_q;
  assign prod     = {32'd0, h_q} * {32'd0, RECIP};
  assign diff     = h_q - qn_q;
  assign p_next   = (p_q == LAST) ? '0 : p_q + 1'b1;
  assign mod_last = IS_POW2 || (step_q == 2'd2);

  // reciprocal estimate is at most one short, so one subtract corrects it
  always_comb begin
    if (IS_POW2) begin
      rem_d = h_q[IW-1:0];
    end else if (diff >= N_W) begin
      rem_d = IW'(diff - N_W);
    end else begin
      rem_d = diff[IW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_q;
    wr_data = '{mark: chi_pkg::MARK_EMPTY, key: '0, value: '0};
    if (cmd_i.clear_wr || cmd_i.copy_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_q;
    end else if (cmd_i.wr_update || cmd_i.wr_place) begin
      wr_en   = 1'b1;
      wr_addr = (cmd_i.wr_place && have_tomb_q) ? tomb_p_q : p_q;
      wr_data = '{mark: chi_pkg::MARK_OCCUPIED, key: work_key_q, value: work_val_q};
    end else if (cmd_i.wr_erase) begin
      wr_en   = 1'b1;
      wr_data = '{mark: chi_pkg::MARK_TOMB, key: slot_rd_q.key, value: '0};
    end
    rd_en   = cmd_i.copy_rd || cmd_i.probe_rd;
    rd_addr = cmd_i.copy_rd ? idx_q : p_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      slot_rd_q <= slot_mem[rd_addr];
    end
    if (cmd_i.copy_wr) begin
      scr_mem[idx_q] <= slot_rd_q;
    end
    if (cmd_i.scan_rd) begin
      scr_rd_q <= scr_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_op_q   <= op_i;
      req_key_q  <= {key_x_i, key_z_i};
      req_val_q  <= value_id_i;
      work_key_q <= {key_x_i, key_z_i};
      work_val_q <= value_id_i;
    end else if (cmd_i.work_from_req) begin
      work_key_q <= req_key_q;
      work_val_q <= req_val_q;
    end else if (cmd_i.work_from_scr) begin
      work_key_q <= scr_rd_q.key;
      work_val_q <= scr_rd_q.value;
    end
    if (cmd_i.hash_x) begin
      hx_q <= work_key_q[63:32] * chi_pkg::HASH_MUL_X;
    end
    if (cmd_i.hash_z) begin
      hz_q <= work_key_q[31:0] * chi_pkg::HASH_MUL_Z;
    end
    if (cmd_i.hash_mix) begin
      h_q    <= mix ^ (mix >> 16);
      step_q <= '0;
    end else if (cmd_i.mod_step) begin
      quo_q  <= prod[63:32];
      qn_q   <= quo_q * N_W;
      step_q <= step_q + 2'd1;
    end
    if (cmd_i.mod_step && mod_last) begin
      p_q         <= rem_d;
      n_q         <= '0;
      have_tomb_q <= 1'b0;
    end else if (cmd_i.probe_adv) begin
      if (slot_rd_q.mark == chi_pkg::MARK_TOMB && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
        tomb_p_q    <= p_q;
      end
      p_q <= p_next;
      n_q <= n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      occ_q       <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc || cmd_i.clear_wr || cmd_i.copy_wr) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.counts_clr) begin
        occ_q  <= '0;
        tcnt_q <= '0;
      end else if (cmd_i.wr_place) begin
        occ_q <= occ_q + 1'b1;
        if ((have_tomb_q || slot_rd_q.mark == chi_pkg::MARK_TOMB) && tcnt_q != '0) begin
          tcnt_q <= tcnt_q - 1'b1;
        end
      end else if (cmd_i.wr_erase) begin
        if (occ_q != '0) begin
          occ_q <= occ_q - 1'b1;
        end
        tcnt_q <= tcnt_q + 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_found_q  <= cmd_i.res_hit ? slot_rd_q.value : '0;
      out_live_q   <= chi_pkg::LIVE_W'(occ_q);
    end
  end

  always_comb begin
    sts_o.rd_mark     = slot_rd_q.mark;
    sts_o.key_eq      = slot_rd_q.key == work_key_q;
    sts_o.n_last      = n_q == LAST;
    sts_o.have_tomb   = have_tomb_q;
    sts_o.tomb_ge_lim = tcnt_q >= CW'(LIMIT);
    sts_o.tomb_nz     = tcnt_q != '0;
    sts_o.idx_last    = idx_q == LAST;
    sts_o.mod_last    = mod_last;
    sts_o.scan_occ    = scr_rd_q.mark == chi_pkg::MARK_OCCUPIED;
    sts_o.req_op      = req_op_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_found_id_o  = out_found_q;
  assign out_occ_count_o = out_live_q;

endmodule

@@ design/chi_ctrl.sv @@
// ----------------------------------------------------------------------------
// chi_ctrl
// sequencer for clear sweep, hashing, probing, rehash and response
// ----------------------------------------------------------------------------
module chi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  chi_pkg::sts_t sts_i,
  output chi_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_HX, S_HZ, S_MIX, S_MOD, S_RD, S_CHK,
    S_RR, S_RW, S_SRD, S_SCHK, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic       rehashing_q, rehashing_d;
  logic       retried_q, retried_d;
  logic [1:0] res_status_q, res_status_d;
  logic       res_hit_q, res_hit_d;
  logic       ins, hit, ins_ok, ins_fail, scan_next;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    rehashing_d  = rehashing_q;
    retried_d    = retried_q;
    res_status_d = res_status_q;
    res_hit_d    = res_hit_q;
    ins          = rehashing_q || sts_i.req_op == chi_pkg::OP_INSERT;
    hit          = sts_i.rd_mark == chi_pkg::MARK_OCCUPIED && sts_i.key_eq;
    ins_ok       = 1'b0;
    ins_fail     = 1'b0;
    scan_next    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          retried_d       = 1'b0;
          state_d         = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.req_op == chi_pkg::OP_INSERT && sts_i.tomb_ge_lim) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_RR;
        end else begin
          state_d = S_HX;
        end
      end
      S_HX: begin
        cmd_o.hash_x = 1'b1;
        state_d      = S_HZ;
      end
      S_HZ: begin
        cmd_o.hash_z = 1'b1;
        state_d      = S_MIX;
      end
      S_MIX: begin
        cmd_o.hash_mix = 1'b1;
        state_d        = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (ins) begin
          if (hit) begin
            cmd_o.wr_update = 1'b1;
            ins_ok          = 1'b1;
          end else if (sts_i.rd_mark == chi_pkg::MARK_EMPTY) begin
            cmd_o.wr_place = 1'b1;
            ins_ok         = 1'b1;
          end else if (sts_i.n_last) begin
            if (sts_i.have_tomb || sts_i.rd_mark == chi_pkg::MARK_TOMB) begin
              cmd_o.wr_place = 1'b1;
              ins_ok         = 1'b1;
            end else begin
              ins_fail = 1'b1;
            end
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d         = S_RD;
          end
          if (rehashing_q && (ins_ok || ins_fail)) begin
            scan_next = 1'b1;
          end else if (ins_ok) begin
            res_status_d = chi_pkg::ST_OK;
            res_hit_d    = 1'b0;
            state_d      = S_DONE;
          end else if (ins_fail) begin
            if (sts_i.tomb_nz && !retried_q) begin
              retried_d     = 1'b1;
              cmd_o.idx_clr = 1'b1;
              state_d       = S_RR;
            end else begin
              res_status_d = chi_pkg::ST_FULL;
              res_hit_d    = 1'b0;
              state_d      = S_DONE;
            end
          end
        end else begin
          if (hit) begin
            res_status_d = chi_pkg::ST_OK;
            if (sts_i.req_op == chi_pkg::OP_ERASE) begin
              cmd_o.wr_erase = 1'b1;
              res_hit_d      = 1'b0;
            end else begin
              res_hit_d = 1'b1;
            end
            state_d = S_DONE;
          end else if (sts_i.rd_mark == chi_pkg::MARK_EMPTY || sts_i.n_last) begin
            res_status_d = chi_pkg::ST_NOTFOUND;
            res_hit_d    = 1'b0;
            state_d      = S_DONE;
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d         = S_RD;
          end
        end
      end
      S_RR: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = S_RW;
      end
      S_RW: begin
        cmd_o.copy_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.counts_clr = 1'b1;
          cmd_o.idx_clr    = 1'b1;
          state_d          = S_SRD;
        end else begin
          state_d = S_RR;
        end
      end
      S_SRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCHK;
      end
      S_SCHK: begin
        if (sts_i.scan_occ) begin
          cmd_o.work_from_scr = 1'b1;
          rehashing_d         = 1'b1;
          state_d             = S_HX;
        end else begin
          scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = res_status_q;
          cmd_o.res_hit    = res_hit_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (scan_next) begin
      if (sts_i.idx_last) begin
        rehashing_d         = 1'b0;
        cmd_o.work_from_req = 1'b1;
        state_d             = S_HX;
      end else begin
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SRD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      rehashing_q  <= 1'b0;
      retried_q    <= 1'b0;
      res_status_q <= chi_pkg::ST_OK;
      res_hit_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rehashing_q  <= rehashing_d;
      retried_q    <= retried_d;
      res_status_q <= res_status_d;
      res_hit_q    <= res_hit_d;
    end
  end

endmodule

@@ design/coord_hash_index_tombstones_top.sv @@
// ----------------------------------------------------------------------------
// coord_hash_index_tombstones_top: linear probing coordinate map, tombstone erase
// items are handled one at a time: hash, modulo reduction, then a read and check per probed slot
// a rehash copies every slot to scratch, then scans the scratch and reinserts each live entry
// reset: clear sweep through the slot memory before first item
// ----------------------------------------------------------------------------
module coord_hash_index_tombstones_top #(
  parameter int unsigned TABLE_ENTRIES = chi_pkg::TABLE_ENTRIES_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  chi_in_if.sink  in_i,
  chi_out_if.source out_o
);

  chi_pkg::cmd_t cmd;
  chi_pkg::sts_t sts;

  chi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chi_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (in_i.op),
    .key_x_i         (in_i.key_x),
    .key_z_i         (in_i.key_z),
    .value_id_i      (in_i.value_id),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_status_o    (out_o.status),
    .out_found_id_o  (out_o.found_id),
    .out_occ_count_o (out_o.occ_count)
  );

  assign in_i.ready = cmd.in_ready;

`ifndef SYNTHESIS
  a_found_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != chi_pkg::ST_OK |-> out_o.found_id == '0)
    else $error("found id on failed item");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status == chi_pkg::ST_OK ||
                     out_o.status == chi_pkg::ST_NOTFOUND ||
                     out_o.status == chi_pkg::ST_FULL))
    else $error("bad status code");
  a_no_ready_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !in_i.ready)
    else $error("response loaded while accepting");
`endif

endmodule
